// ----- hdl/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [3:0] OPC_CLOSE = 4'h8;
   localparam logic [3:0] OPC_DATA_MAX = 4'h2;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT_HI,
      PH_EXT_LO,
      PH_KEY,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_CLOSE   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       end_of_message;
   } result_type;

endpackage

// ----- hdl/wsd_parser.sv -----
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header decoder and payload unmasking; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module wsd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          rx_byte,
   output wsd_pkg::result_type result
);
   import wsd_pkg::*;

   phase_type       phase_ff, phase_in;
   logic [3:0]      opcode_ff, opcode_in;
   logic            mask_ff, mask_in;
   logic [3:0][7:0] key_ff, key_in;
   logic [1:0]      kidx_ff, kidx_in;
   logic [15:0]     left_ff, left_in;
   logic            stopped_ff, stopped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         opcode_ff  <= '0;
         mask_ff    <= 1'b0;
         key_ff     <= '0;
         kidx_ff    <= '0;
         left_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         mask_ff    <= mask_in;
         key_ff     <= key_in;
         kidx_ff    <= kidx_in;
         left_ff    <= left_in;
         stopped_ff <= stopped_in;
      end
   end

   always_comb begin
      logic        after_len;
      logic        hdr_done;
      logic        finish;
      logic [15:0] len_val;
      logic [15:0] left_dec;
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      key_in     = key_ff;
      kidx_in    = kidx_ff;
      left_in    = left_ff;
      stopped_in = stopped_ff;
      result     = '{valid: 1'b0, kind: KIND_PAYLOAD, payload_byte: 8'h00,
                     end_of_message: 1'b0};
      after_len  = 1'b0;
      hdr_done   = 1'b0;
      finish     = 1'b0;
      len_val    = left_ff;
      left_dec   = left_ff - 16'd1;

      if (!stopped_ff) begin
         unique case (phase_ff)
            PH_HDR1: begin
               mask_in = rx_byte[7];
               key_in  = '0;
               if (rx_byte[6:0] == LEN_EXT64) begin
                  stopped_in = 1'b1;
                  phase_in   = PH_HDR0;
                  result     = '{valid: 1'b1, kind: KIND_ERROR, payload_byte: 8'h00,
                                 end_of_message: 1'b1};
               end else if (rx_byte[6:0] == LEN_EXT16) begin
                  phase_in = PH_EXT_HI;
               end else begin
                  len_val   = {9'd0, rx_byte[6:0]};
                  left_in   = len_val;
                  after_len = 1'b1;
               end
            end
            PH_EXT_HI: begin
               left_in  = {rx_byte, 8'h00};
               phase_in = PH_EXT_LO;
            end
            PH_EXT_LO: begin
               len_val   = {left_ff[15:8], rx_byte};
               left_in   = len_val;
               after_len = 1'b1;
            end
            PH_KEY: begin
               key_in[kidx_ff] = rx_byte;
               if (kidx_ff == 2'd3) begin
                  hdr_done = 1'b1;
               end else begin
                  kidx_in = kidx_ff + 2'd1;
               end
            end
            PH_PAYLOAD: begin
               kidx_in = kidx_ff + 2'd1;
               left_in = left_dec;
               if (opcode_ff <= OPC_DATA_MAX) begin
                  result = '{valid: 1'b1, kind: KIND_PAYLOAD,
                             payload_byte: rx_byte ^ key_ff[kidx_ff],
                             end_of_message: (left_dec == 16'd0)};
                  if (left_dec == 16'd0) begin
                     phase_in = PH_HDR0;
                  end
               end else if (left_dec == 16'd0) begin
                  finish = 1'b1;
               end
            end
            default: begin
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase

         if (after_len) begin
            if (mask_in) begin
               kidx_in  = 2'd0;
               phase_in = PH_KEY;
            end else begin
               hdr_done = 1'b1;
            end
         end
         if (hdr_done) begin
            kidx_in = 2'd0;
            if (len_val == 16'd0) begin
               finish = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         if (finish) begin
            phase_in = PH_HDR0;
            if (opcode_ff == OPC_CLOSE) begin
               stopped_in = 1'b1;
               result     = '{valid: 1'b1, kind: KIND_CLOSE, payload_byte: 8'h00,
                              end_of_message: 1'b1};
            end
         end
      end
   end

`ifndef ASSERT_OFF
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped flag cleared without reset");
   a_no_result_stopped: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !result.valid)
      else $error("result produced after close or error");
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != 16'd0))
      else $error("payload phase with no bytes left");
   a_final_eom: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.kind != KIND_PAYLOAD) |-> result.end_of_message)
      else $error("close or error result without end of message");
`endif
endmodule

// ----- hdl/wsd_rsp_reg.sv -----
// ----------------------------------------------------------------------------
// wsd_rsp_reg
// Result register that holds one item until the result channel takes it.
// ----------------------------------------------------------------------------
module wsd_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  wsd_pkg::result_type result,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_end_of_message
);
   import wsd_pkg::*;

   logic       valid_ff;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic       eom_ff;

   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load && result.valid) begin
         kind_ff <= result.kind;
         byte_ff <= result.payload_byte;
         eom_ff  <= result.end_of_message;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_end_of_message = eom_ff;

endmodule

// ----- hdl/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Streams the unmasked payload of received WebSocket frames.
//
//   Channel  Ports                                    Direction
//   req      req_valid req_ready req_rx_byte          in
//   rsp      rsp_valid rsp_ready rsp_kind             out
//            rsp_payload_byte rsp_end_of_message
//
// One item per cycle while the result is not stalled: a byte goes from the
// input register through the header decoder into the result register, so
// its result is valid once it has passed both registers. Reset clears all
// control state. A stalled result holds the result register; the input
// register takes one more item, then req_ready falls until the result is taken.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_end_of_message
);
   import wsd_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_free;
   logic       advance;
   result_type result;

   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   wsd_rsp_reg u_rsp_reg (
      .clock              (clock),
      .reset              (reset),
      .load               (advance),
      .result             (result),
      .free               (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_end_of_message (rsp_end_of_message)
   );

`ifndef ASSERT_OFF
   a_held_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input item lost while result stalled");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input refused with empty input register");
   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid &&
         $stable({rsp_kind, rsp_payload_byte, rsp_end_of_message})))
      else $error("result item changed while stalled");
`endif
endmodule
